@@ hdl/array_linked_list_free_pool_macros.svh @@
// Assertion macros shared by the free pool list RTL.
`ifndef ARRAY_LINKED_LIST_FREE_POOL_MACROS_SVH
`define ARRAY_LINKED_LIST_FREE_POOL_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ALFP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define ALFP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/alfp_pkg.sv @@
// Shared types and constants of the free pool list.
package alfp_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int MAX_RESULTS  = 16;
    localparam int DATA_W       = 32;
    localparam int CNT_W        = $clog2(MAX_RESULTS);

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_WALK   = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_FULL     = 2'd1,
        ST_ELEMENT  = 2'd2,
        ST_EMPTY    = 2'd3
    } t_status;

    // Controller to datapath
    typedef struct packed {
        logic    ins_write;
        logic    walk_start;
        logic    walk_read;
        logic    walk_next;
        logic    out_load;
        t_status out_status;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic out_free;
        logic pool_full;
        logic list_empty;
        logic walk_final;
    } t_dp_sts;

endpackage

@@ hdl/alfp_if.sv @@
// Valid/ready channel interfaces for command items and result items.
interface alfp_in_if;
    logic               valid;
    logic               ready;
    logic               cmd;
    logic signed [31:0] value;

    modport source (output valid, output cmd, output value, input ready);
    modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface alfp_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] data_out;
    logic [1:0]         status;
    logic               last;

    modport source (output valid, output data_out, output status, output last, input ready);
    modport sink   (input valid, input data_out, input status, input last, output ready);
endinterface

@@ hdl/alfp_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module alfp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

@@ hdl/alfp_dp.sv @@
// Datapath: value and link memories, head and free pointers, walk cursor, result register.
module alfp_dp #(
    parameter int CAPACITY = alfp_pkg::CAPACITY_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  alfp_pkg::t_dp_cmd     i_cmd,
    input  logic signed [31:0]    i_value,
    input  logic                  i_out_ready,
    output alfp_pkg::t_dp_sts     o_sts,
    output logic                  o_out_valid,
    output logic signed [31:0]    o_data_out,
    output logic [1:0]            o_status,
    output logic                  o_last
);
    import alfp_pkg::*;

    localparam int SW = $clog2(CAPACITY);
    localparam int LW = $clog2(CAPACITY + 1);
    localparam logic [LW-1:0] NULL_LINK = LW'(CAPACITY);

    logic [LW-1:0]     r_head;
    logic [LW-1:0]     r_free;
    logic [SW-1:0]     r_cur;
    logic [CNT_W-1:0]  r_count;
    logic              r_out_valid;
    logic [DATA_W-1:0] r_data_out;
    t_status           r_status;
    logic              r_last;

    logic [DATA_W-1:0] w_val_rd;
    logic [LW-1:0]     w_link_rd;
    logic              w_final;
    logic              w_is_elem;

    // Slots are never freed, so the free list is always the untouched tail.
    alfp_ram #(.WIDTH(DATA_W), .DEPTH(CAPACITY)) u_val_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.ins_write),
        .i_waddr (r_free[SW-1:0]),
        .i_wdata (i_value),
        .i_re    (i_cmd.walk_read),
        .i_raddr (r_cur),
        .o_rdata (w_val_rd)
    );

    alfp_ram #(.WIDTH(LW), .DEPTH(CAPACITY)) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.ins_write),
        .i_waddr (r_free[SW-1:0]),
        .i_wdata (r_head),
        .i_re    (i_cmd.walk_read),
        .i_raddr (r_cur),
        .o_rdata (w_link_rd)
    );

    assign w_final   = (w_link_rd >= NULL_LINK) || (r_count == CNT_W'(MAX_RESULTS - 1));
    assign w_is_elem = (i_cmd.out_status == ST_ELEMENT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= NULL_LINK;
            r_free      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.ins_write) begin
                r_head <= r_free;
                r_free <= r_free + LW'(1);
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.walk_start) begin
            r_cur   <= r_head[SW-1:0];
            r_count <= '0;
        end else if (i_cmd.walk_next) begin
            r_cur   <= w_link_rd[SW-1:0];
            r_count <= r_count + CNT_W'(1);
        end
        if (i_cmd.out_load) begin
            r_data_out <= w_is_elem ? w_val_rd : '0;
            r_status   <= i_cmd.out_status;
            r_last     <= w_is_elem ? w_final : 1'b1;
        end
    end

    assign o_sts.out_free   = !r_out_valid || i_out_ready;
    assign o_sts.pool_full  = (r_free >= NULL_LINK);
    assign o_sts.list_empty = (r_head >= NULL_LINK);
    assign o_sts.walk_final = w_final;

    assign o_out_valid = r_out_valid;
    assign o_data_out  = r_data_out;
    assign o_status    = r_status;
    assign o_last      = r_last;
endmodule

@@ hdl/alfp_ctrl.sv @@
// Controller: sequences insert and walk commands over the datapath.
module alfp_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_cmd,
    input  alfp_pkg::t_dp_sts i_sts,
    output logic              o_in_ready,
    output alfp_pkg::t_dp_cmd o_cmd
);
    import alfp_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_EMIT = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state          = r_state;
        o_in_ready       = 1'b0;
        o_cmd            = '0;
        o_cmd.out_status = ST_INSERTED;
        case (r_state)
            S_IDLE: begin
                o_in_ready = i_sts.out_free;
                if (i_in_valid && i_sts.out_free) begin
                    if (t_cmd'(i_in_cmd) == CMD_INSERT) begin
                        o_cmd.ins_write  = !i_sts.pool_full;
                        o_cmd.out_load   = 1'b1;
                        o_cmd.out_status = i_sts.pool_full ? ST_FULL : ST_INSERTED;
                    end else if (i_sts.list_empty) begin
                        o_cmd.out_load   = 1'b1;
                        o_cmd.out_status = ST_EMPTY;
                    end else begin
                        o_cmd.walk_start = 1'b1;
                        n_state          = S_READ;
                    end
                end
            end
            S_READ: begin
                o_cmd.walk_read = 1'b1;
                n_state         = S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load   = 1'b1;
                    o_cmd.out_status = ST_ELEMENT;
                    if (i_sts.walk_final) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.walk_next = 1'b1;
                        n_state         = S_READ;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule

@@ hdl/array_linked_list_free_pool.sv @@
// An insert or an empty walk gives its result item in the cycle after acceptance.
// Each walk element item takes a registered memory read, then an emit once output is free.
// Throughput: 1 item per cycle for inserts unless output stalls; a walk blocks new input.
// Reset (synchronous, active low): list empty, all slots free in index order, no result pending.
// Result items wait in an output register, so a stalled consumer only pauses the controller.
`include "array_linked_list_free_pool_macros.svh"
module array_linked_list_free_pool #(
    parameter int CAPACITY = alfp_pkg::CAPACITY_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    alfp_in_if.sink           i_in,
    alfp_out_if.source        o_out
);
    import alfp_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;
    logic    w_in_ready;

    // Controller: decides per cycle which datapath action runs.
    alfp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_cmd   (i_in.cmd),
        .i_sts      (w_sts),
        .o_in_ready (w_in_ready),
        .o_cmd      (w_cmd)
    );

    // Datapath: memories, pointers and the result register.
    alfp_dp #(.CAPACITY(CAPACITY)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_value     (i_in.value),
        .i_out_ready (o_out.ready),
        .o_sts       (w_sts),
        .o_out_valid (o_out.valid),
        .o_data_out  (o_out.data_out),
        .o_status    (o_out.status),
        .o_last      (o_out.last)
    );

    assign i_in.ready = w_in_ready;

    // Never write a slot when the pool is exhausted.
    `ALFP_ASSERT_NOW(a_no_write_when_full, i_clk, i_rst_n, w_cmd.ins_write, !w_sts.pool_full, "insert wrote with no free slot")
    // An accepted insert always shows its result item in the next cycle.
    `ALFP_ASSERT_NEXT(a_insert_result, i_clk, i_rst_n, i_in.valid && i_in.ready && (i_in.cmd == CMD_INSERT), o_out.valid, "insert gave no result item")
    // Starting a walk must be followed by a memory read of the head slot.
    `ALFP_ASSERT_NEXT(a_walk_reads, i_clk, i_rst_n, w_cmd.walk_start, w_cmd.walk_read && !i_in.ready, "walk start not followed by a read")
endmodule

@@ bench/tb_top.sv @@
// Testbench for the array-backed linked list with free pool: LIFO inserts, pool full, walks.
module tb_top;
    import alfp_pkg::*;

    localparam int SLOTS           = CAPACITY_DEF;
    localparam int SLOT_W          = $clog2(SLOTS);
    localparam int LINK_W          = $clog2(SLOTS + 1);
    localparam int PHASE_LEN       = 40;    // accepted commands per idling phase
    localparam int HOLD_OFF_AT     = 165;   // commands taken before the long receiver hold-off
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int STALL_LIMIT     = 3000;  // cycles with no item moving on either channel
    localparam int DRAIN_CYCLES    = 40;
    localparam int RANDOM_CMDS     = 288;

    localparam logic [LINK_W-1:0] NO_SLOT = LINK_W'(SLOTS);

    typedef enum int {
        PH_NO_IDLE,
        PH_SENDER_IDLE,
        PH_RECEIVER_STALL,
        PH_BOTH_IDLE
    } t_idle_phase;

    typedef struct packed {
        t_cmd               cmd;
        logic signed [31:0] value;
    } t_list_cmd;

    typedef struct packed {
        logic signed [31:0] data;
        t_status            status;
        logic               last;
    } t_list_result;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    alfp_in_if  cmd_ch ();
    alfp_out_if res_ch ();

    array_linked_list_free_pool #(
        .CAPACITY (SLOTS)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cmd_ch),
        .o_out   (res_ch)
    );

    always #6 i_clk = ~i_clk;

    // Shadow copy of the list: node storage, links, list head and free pool head.
    logic [31:0]       slot_value [SLOTS];
    logic [LINK_W-1:0] slot_link  [SLOTS];
    logic [LINK_W-1:0] head_ptr;
    logic [LINK_W-1:0] free_ptr;

    t_list_cmd    cmd_backlog [$];   // commands still to be offered
    t_list_result results_due [$];   // result items predicted, not yet seen

    int cmds_taken   = 0;
    int bad_results  = 0;
    int quiet_cycles = 0;
    int hold_left    = 0;
    bit hold_done    = 1'b0;

    // Chain every slot into the free pool in index order; the list starts empty.
    function automatic void clear_shadow_list();
        for (int i = 0; i < SLOTS; i++) begin
            slot_value[i] = '0;
            slot_link[i]  = LINK_W'(i + 1);
        end
        head_ptr = NO_SLOT;
        free_ptr = '0;
    endfunction

    // Apply one accepted command to the shadow list and queue the items it yields.
    function automatic void apply_list_command(t_list_cmd c);
        logic [LINK_W-1:0] slot;
        logic [LINK_W-1:0] cur;
        logic [LINK_W-1:0] nxt;
        int                n;
        if (c.cmd == CMD_INSERT) begin
            slot = free_ptr;
            if (slot >= NO_SLOT) begin
                // Pool exhausted: report full, leave everything as it is.
                results_due.push_back('{32'sd0, ST_FULL, 1'b1});
            end else begin
                // Pop the free slot, fill it, link it in front of the head.
                free_ptr                      = slot_link[slot[SLOT_W-1:0]];
                slot_value[slot[SLOT_W-1:0]]  = c.value;
                slot_link[slot[SLOT_W-1:0]]   = head_ptr;
                head_ptr                      = slot;
                results_due.push_back('{32'sd0, ST_INSERTED, 1'b1});
            end
        end else begin
            cur = head_ptr;
            if (cur >= NO_SLOT) begin
                results_due.push_back('{32'sd0, ST_EMPTY, 1'b1});
            end else begin
                // Follow the chain from head to tail; any out-of-range link ends it.
                n = 0;
                while (cur < NO_SLOT && n < MAX_RESULTS) begin
                    nxt = slot_link[cur[SLOT_W-1:0]];
                    results_due.push_back('{slot_value[cur[SLOT_W-1:0]], ST_ELEMENT,
                                            logic'(nxt >= NO_SLOT || n + 1 == MAX_RESULTS)});
                    n++;
                    cur = nxt;
                end
            end
        end
    endfunction

    function automatic void queue_cmd(t_cmd c, logic [31:0] v);
        cmd_backlog.push_back('{c, v});
    endfunction

    // Phases rotate with the number of commands taken, so gaps land on
    // inserts, empty walks, partial walks, full walks and full-pool inserts.
    function automatic t_idle_phase idle_phase();
        return t_idle_phase'((cmds_taken / PHASE_LEN) % 4);
    endfunction

    function automatic bit chance(int pct);
        return $urandom_range(99) < pct;
    endfunction

    function automatic bit sender_idles();
        case (idle_phase())
            PH_SENDER_IDLE: return chance(83);
            PH_BOTH_IDLE:   return chance(15);
            default:        return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_stalls();
        case (idle_phase())
            PH_RECEIVER_STALL: return chance(83);
            PH_BOTH_IDLE:      return chance(15);
            default:           return 1'b0;
        endcase
    endfunction

    function automatic void note_mismatch(string what, t_list_result want);
        if (bad_results < 10) begin
            $display("%s: expected data=%0d status=%0d last=%0b, got data=%0d status=%0d last=%0b",
                     what, want.data, want.status, want.last,
                     res_ch.data_out, res_ch.status, res_ch.last);
        end
        bad_results++;
    endfunction

    // Command driver: predict on acceptance, then offer the next item or idle.
    always @(posedge i_clk) begin : drive_cmds
        t_list_cmd pick;
        if (!i_rst_n) begin
            cmd_ch.valid <= 1'b0;
            cmd_ch.cmd   <= CMD_INSERT;
            cmd_ch.value <= '0;
        end else begin
            if (cmd_ch.valid && cmd_ch.ready) begin
                apply_list_command('{t_cmd'(cmd_ch.cmd), cmd_ch.value});
                cmds_taken <= cmds_taken + 1;
            end
            // Hold the item until it is taken; only then pick the next one.
            if (!cmd_ch.valid || cmd_ch.ready) begin
                if (cmd_backlog.size() > 0 && !sender_idles()) begin
                    pick = cmd_backlog.pop_front();
                    cmd_ch.valid <= 1'b1;
                    cmd_ch.cmd   <= pick.cmd;
                    cmd_ch.value <= pick.value;
                end else begin
                    cmd_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: compare each taken item with the oldest prediction.
    always @(posedge i_clk) begin : check_results
        t_list_result want;
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                if (results_due.size() == 0) begin
                    note_mismatch("result item with nothing expected", '0);
                end else begin
                    want = results_due.pop_front();
                    if (res_ch.data_out !== want.data || res_ch.status !== want.status ||
                        res_ch.last !== want.last) begin
                        note_mismatch("result item mismatch", want);
                    end
                end
            end
            // Hold ready low for a long stretch once, so the block backs up
            // and drops its input ready while commands keep coming.
            if (!hold_done && cmds_taken >= HOLD_OFF_AT) begin
                hold_done    <= 1'b1;
                hold_left    <= HOLD_OFF_CYCLES;
                res_ch.ready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left    <= hold_left - 1;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= !receiver_stalls();
            end
        end
    end

    // Watchdog: end the run if no item moves on either channel for too long.
    always @(posedge i_clk) begin
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else if (!i_rst_n || (cmd_ch.valid && cmd_ch.ready) ||
                     (res_ch.valid && res_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        cmd_ch.valid = 1'b0;
        cmd_ch.cmd   = CMD_INSERT;
        cmd_ch.value = '0;
        res_ch.ready = 1'b0;
        clear_shadow_list();

        // Directed: empty walk, extreme values, short walks, then fill the
        // pool, walk the full chain, and try one insert with no slot free.
        queue_cmd(CMD_WALK, 32'h0000_0000);
        queue_cmd(CMD_INSERT, 32'h8000_0000);
        queue_cmd(CMD_WALK, 32'hFFFF_FFFF);
        queue_cmd(CMD_INSERT, 32'h7FFF_FFFF);
        queue_cmd(CMD_INSERT, 32'h0000_0000);
        queue_cmd(CMD_INSERT, 32'hFFFF_FFFF);
        queue_cmd(CMD_WALK, 32'h8000_0000);
        queue_cmd(CMD_INSERT, 32'h5555_5555);
        queue_cmd(CMD_INSERT, 32'hAAAA_AAAA);
        for (int i = 0; i < SLOTS - 6; i++) begin
            queue_cmd(CMD_INSERT, $urandom);
        end
        queue_cmd(CMD_WALK, 32'h7FFF_FFFF);
        queue_cmd(CMD_INSERT, 32'h8000_0001);
        queue_cmd(CMD_WALK, 32'h0000_0000);

        // Random: mostly inserts, a third walks; value bits fully random.
        for (int i = 0; i < RANDOM_CMDS; i++) begin
            queue_cmd(($urandom_range(2) == 0) ? CMD_WALK : CMD_INSERT, $urandom);
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for every command to go in and every predicted item to come out.
        while (cmd_backlog.size() != 0 || cmd_ch.valid || results_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (bad_results == 0 && results_due.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
